// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/lds_pkg.sv -----
// Types, constants and the segment table for the LED driver chain serializer.
package lds_pkg;

   // Field widths fixed by the command format.
   localparam int DEVICE_W = 2;
   localparam int BYTE_W   = 8;
   localparam int DIGIT_W  = 3;
   localparam int BIT_W    = 4;

   // Command modes.
   localparam logic MODE_RAW  = 1'b0;
   localparam logic MODE_CHAR = 1'b1;

   // Character ranges recognized in display mode.
   localparam logic [BYTE_W-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_NINE    = 8'h39;
   localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [BYTE_W-1:0] CHAR_UPPER_F = 8'h46;
   localparam logic [BYTE_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [BYTE_W-1:0] CHAR_LOWER_F = 8'h66;
   localparam logic [BYTE_W-1:0] CODE_MAX     = 8'h0F;
   localparam logic [BYTE_W-1:0] HEX_LETTER   = 8'd10;

   // Last bit position within one 16-bit device word.
   localparam logic [BIT_W-1:0] BIT_LAST = 4'hF;

   // Decoded command handed from the decoder to the serializer.
   typedef struct packed {
      logic [BYTE_W-1:0]   address;
      logic [BYTE_W-1:0]   data;
      logic [DEVICE_W-1:0] device;
   } cmd_type;

   // Seven-segment pattern for a code of 0 to 15.
   function automatic logic [BYTE_W-1:0] seg_pattern(input logic [3:0] code);
      logic [BYTE_W-1:0] pattern;
      unique case (code)
         4'd0:    pattern = 8'h7E;
         4'd1:    pattern = 8'h30;
         4'd2:    pattern = 8'h6D;
         4'd3:    pattern = 8'h79;
         4'd4:    pattern = 8'h33;
         4'd5:    pattern = 8'h5B;
         4'd6:    pattern = 8'h5F;
         4'd7:    pattern = 8'h70;
         4'd8:    pattern = 8'h7F;
         4'd9:    pattern = 8'h7B;
         4'd10:   pattern = 8'h77;
         4'd11:   pattern = 8'h1F;
         4'd12:   pattern = 8'h4E;
         4'd13:   pattern = 8'h3D;
         4'd14:   pattern = 8'h4F;
         default: pattern = 8'h47;
      endcase
      return pattern;
   endfunction

endpackage

// ----- src/lds_decode.sv -----
// Command decoder: turns a raw or character command into an address and data byte.
module lds_decode (
   input  logic                         mode,
   input  logic [lds_pkg::DEVICE_W-1:0] device,
   input  logic [lds_pkg::BYTE_W-1:0]   reg_address,
   input  logic [lds_pkg::BYTE_W-1:0]   value,
   input  logic [lds_pkg::DIGIT_W-1:0]  digit,
   output lds_pkg::cmd_type             cmd
);

   logic [lds_pkg::BYTE_W-1:0] code_wide;
   logic [3:0]                 code;

   // Map the character, or a code already of 0 to 15, to a code of 0 to 15; anything else gives 0.
   always_comb begin
      priority if (value >= lds_pkg::CHAR_ZERO && value <= lds_pkg::CHAR_NINE) begin
         code_wide = value - lds_pkg::CHAR_ZERO;
      end else if (value >= lds_pkg::CHAR_LOWER_A && value <= lds_pkg::CHAR_LOWER_F) begin
         code_wide = value - lds_pkg::CHAR_LOWER_A + lds_pkg::HEX_LETTER;
      end else if (value >= lds_pkg::CHAR_UPPER_A && value <= lds_pkg::CHAR_UPPER_F) begin
         code_wide = value - lds_pkg::CHAR_UPPER_A + lds_pkg::HEX_LETTER;
      end else if (value <= lds_pkg::CODE_MAX) begin
         code_wide = value;
      end else begin
         code_wide = '0;
      end
      code = code_wide[3:0];
   end

   // Character mode writes the pattern to register digit plus one; raw mode passes the address and value through.
   always_comb begin
      cmd.device = device;
      if (mode == lds_pkg::MODE_CHAR) begin
         cmd.address = {{(lds_pkg::BYTE_W-lds_pkg::DIGIT_W){1'b0}}, digit} + 8'd1;
         cmd.data    = lds_pkg::seg_pattern(code);
      end else begin
         cmd.address = reg_address;
         cmd.data    = value;
      end
   end

endmodule

// ----- src/lds_serializer.sv -----
// Frame serializer: shifts one device word per chain slot out of a result register.
module lds_serializer #(
   parameter int CHAIN_DEVICES = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  lds_pkg::cmd_type cmd,
   output logic             cmd_take,
   input  logic             rsp_stall,
   output logic             rsp_valid,
   output logic             rsp_serial_bit,
   output logic             rsp_frame_last
);

   localparam logic [lds_pkg::DEVICE_W-1:0] LAST_SLOT =
      lds_pkg::DEVICE_W'(CHAIN_DEVICES - 1);
   localparam logic [lds_pkg::DEVICE_W:0] CHAIN_N = (lds_pkg::DEVICE_W + 1)'(CHAIN_DEVICES);

   logic                         busy_ff, busy_in;
   logic [lds_pkg::DEVICE_W-1:0] slot_ff, slot_in;
   logic [lds_pkg::BIT_W-1:0]    bit_ff, bit_in;
   logic [2*lds_pkg::BYTE_W-1:0] word_ff, word_in;
   logic [lds_pkg::DEVICE_W-1:0] dev_ff, dev_in;
   logic                         match_ff, match_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_bit_ff, rsp_bit_in;
   logic                         rsp_last_ff, rsp_last_in;
   logic                         out_adv;
   logic                         at_last;
   logic                         cur_bit;

   // Current bit: only the addressed slot carries data, MSB first.
   always_comb begin
      out_adv  = !rsp_valid_ff || !rsp_stall;
      at_last  = (slot_ff == LAST_SLOT) && (bit_ff == lds_pkg::BIT_LAST);
      cur_bit  = match_ff && (slot_ff == dev_ff) && word_ff[~bit_ff];
      cmd_take = cmd_valid && (!busy_ff || (out_adv && at_last));
   end

   // Advance the bit counter and fill the result register.
   always_comb begin
      busy_in      = busy_ff;
      slot_in      = slot_ff;
      bit_in       = bit_ff;
      word_in      = word_ff;
      dev_in       = dev_ff;
      match_in     = match_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_bit_in   = rsp_bit_ff;
      rsp_last_in  = rsp_last_ff;
      if (out_adv) begin
         rsp_valid_in = busy_ff;
         if (busy_ff) begin
            rsp_bit_in  = cur_bit;
            rsp_last_in = at_last;
            bit_in      = bit_ff + 4'd1;
            if (bit_ff == lds_pkg::BIT_LAST) begin
               slot_in = slot_ff + 2'd1;
            end
            if (at_last) begin
               busy_in = 1'b0;
            end
         end
      end
      // A new frame starts as soon as the previous one hands out its last bit.
      if (cmd_take) begin
         busy_in  = 1'b1;
         slot_in  = '0;
         bit_in   = '0;
         word_in  = {cmd.address, cmd.data};
         dev_in   = cmd.device;
         match_in = {1'b0, cmd.device} < CHAIN_N;
      end
   end

   // Only the busy and valid flags are reset; the counters and payload registers are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      slot_ff     <= slot_in;
      bit_ff      <= bit_in;
      word_ff     <= word_in;
      dev_ff      <= dev_in;
      match_ff    <= match_in;
      rsp_bit_ff  <= rsp_bit_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_serial_bit = rsp_bit_ff;
   assign rsp_frame_last = rsp_last_ff;

endmodule

// ----- src/led_driver_chain_serializer.sv -----
// Top level of the LED driver chain serializer: input register, decoder and serializer.
//
// The req_ channel takes one command per transfer: a raw register write
// (mode 0) or a character for one digit (mode 1), aimed at one device slot.
// Each command produces a frame of CHAIN_DEVICES words of 16 bits, slot 0
// first, address byte then data byte, MSB first; every slot but the
// addressed one carries a zero word. A device index beyond the chain sends
// an all-zero frame. The rsp_ channel moves one bit per transfer, and
// rsp_frame_last marks the final bit so chip select can be released after it.
// When the block is idle, a command passes through the input register, the
// serializer's word register and the result register before its first bit appears.
// The serializer shifts one bit per cycle while the receiver does not stall; the
// next command is held in the input register and its frame follows the previous
// last bit without a gap, so a command can be taken while a frame is still shifting.
// When the receiver stalls, the result register holds its bit, the serializer
// waits, and req_stall rises once the input register is full.
// Synchronous reset empties the input register and the serializer.
module led_driver_chain_serializer #(
   parameter int CHAIN_DEVICES = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_mode,
   input  logic [lds_pkg::DEVICE_W-1:0] req_device,
   input  logic [lds_pkg::BYTE_W-1:0]   req_reg_address,
   input  logic [lds_pkg::BYTE_W-1:0]   req_value,
   input  logic [lds_pkg::DIGIT_W-1:0]  req_digit,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_serial_bit,
   output logic                         rsp_frame_last
);

   logic                         in_valid_ff, in_valid_in;
   logic                         in_mode_ff, in_mode_in;
   logic [lds_pkg::DEVICE_W-1:0] in_device_ff, in_device_in;
   logic [lds_pkg::BYTE_W-1:0]   in_address_ff, in_address_in;
   logic [lds_pkg::BYTE_W-1:0]   in_value_ff, in_value_in;
   logic [lds_pkg::DIGIT_W-1:0]  in_digit_ff, in_digit_in;
   logic                         req_take;
   logic                         cmd_take;
   lds_pkg::cmd_type             cmd;

   // The input register takes a transfer whenever it is empty or being drained.
   always_comb begin
      req_stall     = in_valid_ff && !cmd_take;
      req_take      = req_valid && !req_stall;
      in_valid_in   = req_take || (in_valid_ff && !cmd_take);
      in_mode_in    = in_mode_ff;
      in_device_in  = in_device_ff;
      in_address_in = in_address_ff;
      in_value_in   = in_value_ff;
      in_digit_in   = in_digit_ff;
      if (req_take) begin
         in_mode_in    = req_mode;
         in_device_in  = req_device;
         in_address_in = req_reg_address;
         in_value_in   = req_value;
         in_digit_in   = req_digit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_mode_ff    <= in_mode_in;
      in_device_ff  <= in_device_in;
      in_address_ff <= in_address_in;
      in_value_ff   <= in_value_in;
      in_digit_ff   <= in_digit_in;
   end

   // Decode the held command into an address and data byte.
   lds_decode u_decode (
      .mode        (in_mode_ff),
      .device      (in_device_ff),
      .reg_address (in_address_ff),
      .value       (in_value_ff),
      .digit       (in_digit_ff),
      .cmd         (cmd)
   );

   // Shift the frame out one bit per result transfer.
   lds_serializer #(
      .CHAIN_DEVICES (CHAIN_DEVICES)
   ) u_serializer (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (in_valid_ff),
      .cmd            (cmd),
      .cmd_take       (cmd_take),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_serial_bit (rsp_serial_bit),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule

// ----- src/lds_checker.sv -----
// Port-level checker for the LED driver chain serializer, bound to the top level.
`include "assert_macros.svh"

module lds_checker #(
   parameter int CHAIN_DEVICES = 4
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_serial_bit,
   input logic rsp_frame_last
);

   localparam int FRAME_BITS = CHAIN_DEVICES * 16;
   localparam int CNT_W      = $clog2(FRAME_BITS);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAME_BITS - 1);

   logic [CNT_W-1:0] pos_ff, pos_in;
   logic             rsp_xfer;

   // Position of the next result transfer within its frame.
   always_comb begin
      rsp_xfer = rsp_valid && !rsp_stall;
      pos_in   = pos_ff;
      if (rsp_xfer) begin
         pos_in = (pos_ff == CNT_LAST) ? '0 : pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   `ASSERT_ALWAYS(a_reset_rsp_idle, clock, reset |=> !rsp_valid, "result valid after reset")
   `ASSERT_ALWAYS(a_reset_req_open, clock, reset |=> !req_stall, "request stalled after reset")
   `ASSERT_CLK(a_frame_len, clock, reset,
      rsp_xfer |-> (rsp_frame_last == (pos_ff == CNT_LAST)), "frame last flag misplaced")
   `ASSERT_CLK(a_rsp_hold, clock, reset,
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_serial_bit)
         && $stable(rsp_frame_last), "stalled result changed")

endmodule

bind led_driver_chain_serializer lds_checker #(
   .CHAIN_DEVICES (CHAIN_DEVICES)
) u_lds_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_serial_bit (rsp_serial_bit),
   .rsp_frame_last (rsp_frame_last)
);
